// ===== design/erht_pkg.sv =====
// Shared types and constants for the expiring route hash table.
// No dependencies.
package erht_pkg;

   localparam int SLOTS = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = SLOT_W + 1;
   localparam int FILL_W = 7;
   localparam int LIVE_W = 7;
   localparam int SUM_W = (CNT_W + 1 > FILL_W) ? CNT_W + 1 : FILL_W;

   localparam logic [31:0] HASH_MUL = 32'h045d_9f3b;
   localparam logic [31:0] VALIDITY_RESET = 32'd2400;
   localparam logic [FILL_W-1:0] FILL_RESET = 7'd45;

   localparam logic [1:0] ACT_UPDATE = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_PURGE = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_STALE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic CSR_VALIDITY = 1'b0;
   localparam logic CSR_FILL = 1'b1;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] hop;
      logic [31:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== design/erht_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
// No dependencies.
module erht_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/erht_hash.sv =====
// Two-stage pipelined multiply-xor hash giving the home slot of a key.
// Depends on erht_pkg.
module erht_hash (
   input  logic                        clock,
   input  logic [31:0]                 key_in,
   output logic [erht_pkg::SLOT_W-1:0] home_out
);

   logic [31:0] mul1_ff;
   logic [31:0] mul1_in;
   logic [31:0] mul2_ff;
   logic [31:0] mul2_in;
   logic [31:0] mix1;
   logic [31:0] mix2;
   logic [31:0] mix3;

   always_comb begin
      mix1 = key_in ^ (key_in >> 16);
      mul1_in = mix1 * erht_pkg::HASH_MUL;
      mix2 = mul1_ff ^ (mul1_ff >> 16);
      mul2_in = mix2 * erht_pkg::HASH_MUL;
      mix3 = mul2_ff ^ (mul2_ff >> 16);
   end

   always_ff @(posedge clock) begin
      mul1_ff <= mul1_in;
      mul2_ff <= mul2_in;
   end

   assign home_out = mix3[erht_pkg::SLOT_W-1:0];

endmodule

// ===== design/expiring_route_hash_table.sv =====
// Expiring route hash table: sequencer, slot marks and counters around two RAMs.
// Update and lookup hash the key, then probe: a used slot is read and its key compared,
// a tombstone is skipped, and an empty slot or a full wrap of the table ends the probe.
// Purge scans every slot, reading used ones; if tombstones remain, kept entries are rebuilt.
// One transaction at a time; a waiting result delays the next result but not its acceptance.
// Synchronous reset clears the slot marks and counters at once; no clearing pass is needed.
module expiring_route_hash_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_node_id,
   input  logic [31:0] req_hop_in,
   input  logic [31:0] req_time_stamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_hop_out,
   output logic [6:0]  rsp_live_entries,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_H1 = 4'd1;
   localparam logic [3:0] S_H2 = 4'd2;
   localparam logic [3:0] S_H3 = 4'd3;
   localparam logic [3:0] S_PRB = 4'd4;
   localparam logic [3:0] S_CMP = 4'd5;
   localparam logic [3:0] S_ACT = 4'd6;
   localparam logic [3:0] S_PRD = 4'd7;
   localparam logic [3:0] S_PCK = 4'd8;
   localparam logic [3:0] S_RCLR = 4'd9;
   localparam logic [3:0] S_RRD = 4'd10;
   localparam logic [3:0] S_RLD = 4'd11;
   localparam logic [3:0] S_OUT = 4'd12;

   localparam int SW = erht_pkg::SLOT_W;
   localparam int CW = erht_pkg::CNT_W;
   localparam int UW = erht_pkg::SUM_W;

   logic [3:0] state_ff, state_in;
   logic [31:0] valid_sec_ff, valid_sec_in;
   logic [erht_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [erht_pkg::SLOTS-1:0] used_ff, used_in;
   logic [erht_pkg::SLOTS-1:0] tomb_ff, tomb_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] tcnt_ff, tcnt_in;
   logic [1:0] act_ff, act_in;
   logic reb_ff, reb_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] hop_ff, hop_in;
   logic [31:0] ts_ff, ts_in;
   logic [SW-1:0] p_ff, p_in;
   logic [CW-1:0] i_ff, i_in;
   logic tseen_ff, tseen_in;
   logic [SW-1:0] tpos_ff, tpos_in;
   logic hit_ff, hit_in;
   logic hs_ff, hs_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [31:0] ehop_ff, ehop_in;
   logic [31:0] etime_ff, etime_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] j_ff, j_in;
   logic [1:0] status_ff, status_in;
   logic [31:0] hopo_ff, hopo_in;
   logic rv_ff, rv_in;
   logic [1:0] rst_ff, rst_in;
   logic [31:0] rhop_ff, rhop_in;
   logic [6:0] rlive_ff, rlive_in;

   logic [SW-1:0] home;
   logic ent_we, ent_re, scr_we, scr_re;
   logic [SW-1:0] ent_ra, scr_wa, scr_ra;
   erht_pkg::entry_type ent_wd, ent_rd, scr_rd;
   logic [UW-1:0] fill_sum;
   logic [31:0] age_probe, age_scan;

   erht_hash u_hash (
      .clock    (clock),
      .key_in   (key_ff),
      .home_out (home)
   );

   erht_ram #(.WIDTH(erht_pkg::ENTRY_W), .DEPTH(erht_pkg::SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (pos_ff),
      .wr_data (ent_wd),
      .rd_en   (ent_re),
      .rd_addr (ent_ra),
      .rd_data (ent_rd)
   );

   erht_ram #(.WIDTH(erht_pkg::ENTRY_W), .DEPTH(erht_pkg::SLOTS)) u_scratch_ram (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (scr_wa),
      .wr_data (ent_rd),
      .rd_en   (scr_re),
      .rd_addr (scr_ra),
      .rd_data (scr_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_status = rst_ff;
   assign rsp_hop_out = rhop_ff;
   assign rsp_live_entries = rlive_ff;

   always_comb begin
      state_in = state_ff;
      valid_sec_in = valid_sec_ff;
      fill_in = fill_ff;
      used_in = used_ff;
      tomb_in = tomb_ff;
      occ_in = occ_ff;
      tcnt_in = tcnt_ff;
      act_in = act_ff;
      reb_in = reb_ff;
      key_in = key_ff;
      hop_in = hop_ff;
      ts_in = ts_ff;
      p_in = p_ff;
      i_in = i_ff;
      tseen_in = tseen_ff;
      tpos_in = tpos_ff;
      hit_in = hit_ff;
      hs_in = hs_ff;
      pos_in = pos_ff;
      ehop_in = ehop_ff;
      etime_in = etime_ff;
      n_in = n_ff;
      j_in = j_ff;
      status_in = status_ff;
      hopo_in = hopo_ff;
      rv_in = rv_ff;
      rst_in = rst_ff;
      rhop_in = rhop_ff;
      rlive_in = rlive_ff;
      ent_we = 1'b0;
      ent_re = 1'b0;
      ent_ra = p_ff;
      scr_we = 1'b0;
      scr_wa = n_ff[SW-1:0];
      scr_re = 1'b0;
      scr_ra = j_ff[SW-1:0];
      ent_wd = '{key: key_ff, hop: hop_ff, stamp: ts_ff};
      fill_sum = UW'(occ_ff) + UW'(tcnt_ff);
      age_probe = ts_ff - etime_ff;
      age_scan = ts_ff - ent_rd.stamp;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      if (csr_valid) begin
         if (csr_index == erht_pkg::CSR_VALIDITY) begin
            valid_sec_in = csr_data;
         end else begin
            fill_in = csr_data[erht_pkg::FILL_W-1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               key_in = req_node_id;
               hop_in = req_hop_in;
               ts_in = req_time_stamp;
               status_in = erht_pkg::ST_DONE;
               hopo_in = '0;
               reb_in = 1'b0;
               n_in = '0;
               i_in = '0;
               case (req_action)
                  erht_pkg::ACT_PURGE: begin
                     state_in = S_PRD;
                  end
                  erht_pkg::ACT_CLEAR: begin
                     used_in = '0;
                     tomb_in = '0;
                     occ_in = '0;
                     tcnt_in = '0;
                     state_in = S_OUT;
                  end
                  default: begin
                     state_in = S_H1;
                  end
               endcase
            end
         end
         S_H1: begin
            state_in = S_H2;
         end
         S_H2: begin
            state_in = S_H3;
         end
         S_H3: begin
            p_in = home;
            i_in = '0;
            tseen_in = 1'b0;
            tpos_in = '0;
            state_in = S_PRB;
         end
         S_PRB: begin
            if (i_ff == CW'(erht_pkg::SLOTS)) begin
               hit_in = 1'b0;
               hs_in = tseen_ff;
               pos_in = tpos_ff;
               state_in = S_ACT;
            end else if (!used_ff[p_ff] && !tomb_ff[p_ff]) begin
               hit_in = 1'b0;
               hs_in = 1'b1;
               pos_in = tseen_ff ? tpos_ff : p_ff;
               state_in = S_ACT;
            end else if (tomb_ff[p_ff]) begin
               if (!tseen_ff) begin
                  tseen_in = 1'b1;
                  tpos_in = p_ff;
               end
               p_in = p_ff + 1'b1;
               i_in = i_ff + 1'b1;
            end else begin
               ent_re = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (ent_rd.key == key_ff) begin
               hit_in = 1'b1;
               hs_in = 1'b1;
               pos_in = p_ff;
               ehop_in = ent_rd.hop;
               etime_in = ent_rd.stamp;
               state_in = S_ACT;
            end else begin
               p_in = p_ff + 1'b1;
               i_in = i_ff + 1'b1;
               state_in = S_PRB;
            end
         end
         S_ACT: begin
            state_in = S_OUT;
            if (reb_ff) begin
               if (hs_ff) begin
                  ent_we = 1'b1;
                  used_in[pos_ff] = 1'b1;
                  occ_in = occ_ff + 1'b1;
               end
               j_in = j_ff + 1'b1;
               if (j_ff + 1'b1 != n_ff) begin
                  state_in = S_RRD;
               end
            end else if (act_ff == erht_pkg::ACT_LOOKUP) begin
               if (hit_ff && age_probe < valid_sec_ff) begin
                  hopo_in = ehop_ff;
               end
            end else if (hit_ff) begin
               if (ts_ff <= etime_ff) begin
                  status_in = erht_pkg::ST_STALE;
               end else begin
                  ent_we = 1'b1;
               end
            end else if (fill_sum >= UW'(fill_ff) || !hs_ff) begin
               status_in = erht_pkg::ST_FULL;
            end else begin
               if (tomb_ff[pos_ff]) begin
                  tcnt_in = tcnt_ff - 1'b1;
               end
               tomb_in[pos_ff] = 1'b0;
               used_in[pos_ff] = 1'b1;
               occ_in = occ_ff + 1'b1;
               ent_we = 1'b1;
            end
         end
         S_PRD: begin
            ent_ra = i_ff[SW-1:0];
            if (i_ff == CW'(erht_pkg::SLOTS)) begin
               state_in = (tcnt_ff != '0) ? S_RCLR : S_OUT;
            end else if (used_ff[i_ff[SW-1:0]]) begin
               ent_re = 1'b1;
               state_in = S_PCK;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_PCK: begin
            if (age_scan >= valid_sec_ff) begin
               used_in[i_ff[SW-1:0]] = 1'b0;
               tomb_in[i_ff[SW-1:0]] = 1'b1;
               occ_in = occ_ff - 1'b1;
               tcnt_in = tcnt_ff + 1'b1;
            end else begin
               scr_we = 1'b1;
               n_in = n_ff + 1'b1;
            end
            i_in = i_ff + 1'b1;
            state_in = S_PRD;
         end
         S_RCLR: begin
            used_in = '0;
            tomb_in = '0;
            occ_in = '0;
            tcnt_in = '0;
            j_in = '0;
            reb_in = 1'b1;
            state_in = (n_ff == '0) ? S_OUT : S_RRD;
         end
         S_RRD: begin
            scr_re = 1'b1;
            state_in = S_RLD;
         end
         S_RLD: begin
            key_in = scr_rd.key;
            hop_in = scr_rd.hop;
            ts_in = scr_rd.stamp;
            state_in = S_H1;
         end
         S_OUT: begin
            if (!(rv_ff && rsp_stall)) begin
               rv_in = 1'b1;
               rst_in = status_ff;
               rhop_in = hopo_ff;
               rlive_in = erht_pkg::LIVE_W'(occ_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_sec_ff <= erht_pkg::VALIDITY_RESET;
         fill_ff <= erht_pkg::FILL_RESET;
         used_ff <= '0;
         tomb_ff <= '0;
         occ_ff <= '0;
         tcnt_ff <= '0;
         rv_ff <= 1'b0;
         reb_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_sec_ff <= valid_sec_in;
         fill_ff <= fill_in;
         used_ff <= used_in;
         tomb_ff <= tomb_in;
         occ_ff <= occ_in;
         tcnt_ff <= tcnt_in;
         rv_ff <= rv_in;
         reb_ff <= reb_in;
      end
      act_ff <= act_in;
      key_ff <= key_in;
      hop_ff <= hop_in;
      ts_ff <= ts_in;
      p_ff <= p_in;
      i_ff <= i_in;
      tseen_ff <= tseen_in;
      tpos_ff <= tpos_in;
      hit_ff <= hit_in;
      hs_ff <= hs_in;
      pos_ff <= pos_in;
      ehop_ff <= ehop_in;
      etime_ff <= etime_in;
      n_ff <= n_in;
      j_ff <= j_in;
      status_ff <= status_in;
      hopo_ff <= hopo_in;
      rst_ff <= rst_in;
      rhop_ff <= rhop_in;
      rlive_ff <= rlive_in;
   end

`ifndef SYNTHESIS
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(occ_ff))
      else $error("occupied count differs from used marks");
   a_tomb_count: assert property (@(posedge clock) disable iff (reset)
      $countones(tomb_ff) == int'(tcnt_ff))
      else $error("tombstone count differs from tombstone marks");
   a_mark_excl: assert property (@(posedge clock) disable iff (reset)
      (used_ff & tomb_ff) == '0)
      else $error("slot marked both used and tombstone");
   a_idle_after_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rv_ff) |=> (rv_ff && state_ff == S_IDLE))
      else $error("result not delivered from output state");
`endif

endmodule
